@@ rtl/core/dwgp_pkg.sv @@
// Shared widths, constants, register indexes and types of the depth pseudocolor unit.
package dwgp_pkg;

  localparam int FRAC_BITS   = 16;

  localparam int DEPTH_W     = 16;
  localparam int GRAY_SC_W   = 24;
  localparam int COLOR_SC_W  = 26;
  localparam int CFG_DATA_W  = 26;
  localparam int CFG_IDX_W   = 2;
  localparam int PIX_W       = 8;
  localparam int CIDX_W      = 10;

  localparam int GRAY_PROD_W  = DEPTH_W + GRAY_SC_W;
  localparam int COLOR_PROD_W = DEPTH_W + COLOR_SC_W;
  localparam int GRAY_Q_W     = GRAY_PROD_W - FRAC_BITS;
  localparam int COLOR_Q_W    = COLOR_PROD_W - FRAC_BITS;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_DEPTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DEPTH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GRAY_SCALE  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_SCALE = 2'd3;

  localparam logic [DEPTH_W-1:0]    RST_MIN_DEPTH   = 16'd0;
  localparam logic [DEPTH_W-1:0]    RST_MAX_DEPTH   = 16'd30000;
  localparam logic [GRAY_SC_W-1:0]  RST_GRAY_SCALE  = 24'd557;
  localparam logic [COLOR_SC_W-1:0] RST_COLOR_SCALE = 26'd1953;

  localparam logic [CIDX_W-1:0] GRAY_MAX   = 10'd255;
  localparam logic [CIDX_W-1:0] COLOR_MAX  = 10'd894;
  localparam logic [CIDX_W-1:0] KNEE_ORANGE = 10'd64;
  localparam logic [CIDX_W-1:0] KNEE_YELLOW = 10'd255;
  localparam logic [CIDX_W-1:0] KNEE_CYAN   = 10'd510;
  localparam logic [CIDX_W-1:0] KNEE_BLUE   = 10'd765;
  localparam logic [CIDX_W-1:0] RED_BASE    = 10'd191;
  localparam logic [CIDX_W-1:0] FADE_TOP    = 10'd1020;

  typedef struct packed {
    logic [DEPTH_W-1:0]    min_depth;
    logic [DEPTH_W-1:0]    max_depth;
    logic [GRAY_SC_W-1:0]  gray_scale;
    logic [COLOR_SC_W-1:0] color_scale;
  } dwgp_cfg_t;

  typedef struct packed {
    logic [PIX_W-1:0] gray;
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
  } dwgp_pix_t;

endpackage

@@ rtl/core/dwgp_cfg_regs.sv @@
// Configuration register file of the depth pseudocolor unit.
module dwgp_cfg_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [dwgp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dwgp_pkg::CFG_DATA_W-1:0]  cfg_data,
  output dwgp_pkg::dwgp_cfg_t              cfg
);
  import dwgp_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_depth   <= RST_MIN_DEPTH;
      cfg.max_depth   <= RST_MAX_DEPTH;
      cfg.gray_scale  <= RST_GRAY_SCALE;
      cfg.color_scale <= RST_COLOR_SCALE;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_MIN_DEPTH:   cfg.min_depth   <= cfg_data[DEPTH_W-1:0];
        REG_MAX_DEPTH:   cfg.max_depth   <= cfg_data[DEPTH_W-1:0];
        REG_GRAY_SCALE:  cfg.gray_scale  <= cfg_data[GRAY_SC_W-1:0];
        REG_COLOR_SCALE: cfg.color_scale <= cfg_data[COLOR_SC_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/core/dwgp_map.sv @@
// Clamp, fixed-point scaling and color ramp for one depth pixel.
module dwgp_map (
  input  dwgp_pkg::dwgp_cfg_t            cfg,
  input  logic [dwgp_pkg::DEPTH_W-1:0]   depth,
  output dwgp_pkg::dwgp_pix_t            pix
);
  import dwgp_pkg::*;

  logic [DEPTH_W-1:0]      clamped;
  logic [DEPTH_W-1:0]      offset;
  logic [GRAY_PROD_W-1:0]  gray_prod;
  logic [COLOR_PROD_W-1:0] color_prod;
  logic [GRAY_Q_W-1:0]     gray_q;
  logic [COLOR_Q_W-1:0]    color_q;
  logic [CIDX_W-1:0]       g;
  logic [CIDX_W-1:0]       c;
  logic [CIDX_W-1:0]       r;
  logic [CIDX_W-1:0]       gr;
  logic [CIDX_W-1:0]       b;
  logic [CIDX_W-1:0]       inv;

  always_comb begin
    if (depth > cfg.max_depth) begin
      clamped = cfg.max_depth;
    end else if (depth < cfg.min_depth) begin
      clamped = cfg.min_depth;
    end else begin
      clamped = depth;
    end
    // An inverted window can leave the clamped value under the minimum.
    offset = (clamped >= cfg.min_depth) ? clamped - cfg.min_depth : '0;
  end

  assign gray_prod  = GRAY_PROD_W'(offset) * GRAY_PROD_W'(cfg.gray_scale);
  assign color_prod = COLOR_PROD_W'(offset) * COLOR_PROD_W'(cfg.color_scale);
  assign gray_q     = gray_prod[GRAY_PROD_W-1:FRAC_BITS];
  assign color_q    = color_prod[COLOR_PROD_W-1:FRAC_BITS];

  always_comb begin
    g = (gray_q > GRAY_Q_W'(GRAY_MAX)) ? GRAY_MAX : gray_q[CIDX_W-1:0];
    c = (color_q > COLOR_Q_W'(COLOR_MAX)) ? COLOR_MAX : color_q[CIDX_W-1:0];
    inv = GRAY_MAX - g;

    if (c < KNEE_ORANGE) begin
      r = RED_BASE + c;  gr = c;  b = '0;
    end else if (c < KNEE_YELLOW) begin
      r = GRAY_MAX;      gr = c;  b = '0;
    end else if (c < KNEE_CYAN) begin
      r = KNEE_CYAN - c; gr = GRAY_MAX; b = c - KNEE_YELLOW;
    end else if (c < KNEE_BLUE) begin
      r = '0;            gr = KNEE_BLUE - c; b = GRAY_MAX;
    end else begin
      r = '0;            gr = '0; b = FADE_TOP - c;
    end

    pix.gray  = inv[PIX_W-1:0];
    pix.red   = r[PIX_W-1:0];
    pix.green = gr[PIX_W-1:0];
    pix.blue  = b[PIX_W-1:0];
  end

endmodule

@@ rtl/core/depth_window_gray_pseudocolor_unit.sv @@
// Top level of the depth window gray and pseudocolor unit.
//
//   channel  direction  handshake              payload
//   input    in         in_valid / in_stall    depth_in[15:0]
//   output   out        out_valid / out_stall  gray_out, red_out, green_out, blue_out [7:0]
//   config   in         cfg_write              cfg_index[1:0], cfg_data[25:0]
//
// Each beat sits in the input register, then the clamp, two multipliers and ramp settle
// into the result register, where out_valid marks it. One beat is accepted every cycle
// while no stalled result blocks a full input register; the multiplier path to the result
// register sets the clock limit. Reset (rst, synchronous) empties both registers and
// restores the configuration defaults. A stalled result holds; the input register still
// fills behind it, so one more beat is taken before in_stall rises.
module depth_window_gray_pseudocolor_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [dwgp_pkg::DEPTH_W-1:0]     depth_in,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [dwgp_pkg::PIX_W-1:0]       gray_out,
  output logic [dwgp_pkg::PIX_W-1:0]       red_out,
  output logic [dwgp_pkg::PIX_W-1:0]       green_out,
  output logic [dwgp_pkg::PIX_W-1:0]       blue_out,
  input  logic                             cfg_write,
  input  logic [dwgp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dwgp_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import dwgp_pkg::*;

  dwgp_cfg_t          cfg;
  dwgp_pix_t          pix_next;
  dwgp_pix_t          pix;
  logic               s1_valid;
  logic [DEPTH_W-1:0] s1_depth;
  logic               advance;
  logic               s1_load;

  dwgp_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  dwgp_map u_map (
    .cfg   (cfg),
    .depth (s1_depth),
    .pix   (pix_next)
  );

  // The result register moves whenever it is empty or being taken.
  assign advance  = !(out_valid && out_stall);
  // The input register refills when it is empty or its beat moves on.
  assign s1_load  = !s1_valid || advance;
  assign in_stall = !s1_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_load) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_depth <= depth_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      pix <= pix_next;
    end
  end

  assign gray_out  = pix.gray;
  assign red_out   = pix.red;
  assign green_out = pix.green;
  assign blue_out  = pix.blue;

  // An accepted beat always lands in the input register.
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> s1_valid)
    else $error("accepted beat missing from input register");

  // A beat held in the input register behind a stalled result is not dropped.
  a_hold_s1: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !advance |=> s1_valid && $stable(s1_depth))
    else $error("input register lost a waiting beat");

  // A beat that moves on from the input register shows up as a result.
  a_move_out: assert property (@(posedge clk) disable iff (rst)
    s1_valid && advance |=> out_valid)
    else $error("beat vanished between input and result register");

  // With nothing behind it, a taken result leaves the output empty.
  a_no_repeat: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !s1_valid |=> !out_valid)
    else $error("result repeated after being taken");

endmodule
